/* hdl/tic_pkg.sv */
// Shared types, constants and helpers for the turn indicator controller.
`default_nettype none

package tic_pkg;

  localparam int unsigned CountWidth = 8;
  localparam int unsigned FlashWidth = 4;
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth = 8;

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [FlashWidth-1:0] flash_t;

  typedef enum logic [3:0] {
    MODE_OFF    = 4'b0001,
    MODE_LANE   = 4'b0010,
    MODE_NORMAL = 4'b0100,
    MODE_HAZARD = 4'b1000
  } mode_t;

  localparam logic [1:0] MODE_CODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_CODE_LANE   = 2'd1;
  localparam logic [1:0] MODE_CODE_NORMAL = 2'd2;
  localparam logic [1:0] MODE_CODE_HAZARD = 2'd3;

  localparam logic [1:0] SIDE_NONE  = 2'd0;
  localparam logic [1:0] SIDE_LEFT  = 2'd1;
  localparam logic [1:0] SIDE_RIGHT = 2'd2;

  localparam logic [1:0] LAMP_NONE = 2'b00;
  localparam logic [1:0] LAMP_LOW  = 2'b01;
  localparam logic [1:0] LAMP_HIGH = 2'b10;
  localparam logic [1:0] LAMP_BOTH = 2'b11;

  localparam logic [CfgIndexWidth-1:0] CFG_HAZARD_HOLD  = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_TURN_HOLD    = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_RELEASE      = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_TURN_ON      = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_FLASH_PERIOD = 3'd4;
  localparam logic [CfgIndexWidth-1:0] CFG_HAZARD_ON    = 3'd5;
  localparam logic [CfgIndexWidth-1:0] CFG_LANE_FLASHES = 3'd6;

  typedef struct packed {
    count_t hazard_hold_ticks;
    count_t turn_hold_ticks;
    count_t release_ticks;
    count_t turn_on_ticks;
    count_t flash_period_ticks;
    count_t hazard_on_ticks;
    flash_t lane_flash_count;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    hazard_hold_ticks:  8'd20,
    turn_hold_ticks:    8'd50,
    release_ticks:      8'd10,
    turn_on_ticks:      8'd30,
    flash_period_ticks: 8'd100,
    hazard_on_ticks:    8'd50,
    lane_flash_count:   4'd3
  };

  typedef struct packed {
    mode_t      mode;
    logic [1:0] saved_side;
    logic [1:0] lamp_bits;
    count_t     normal_hazard_count;
    count_t     normal_phase_count;
    count_t     normal_release_count;
    count_t     lane_hazard_count;
    count_t     lane_left_count;
    count_t     lane_right_count;
    flash_t     lane_flashes_done;
    count_t     lane_phase_count;
    count_t     hazard_exit_count;
    count_t     hazard_phase_count;
    count_t     off_hazard_count;
    count_t     off_left_count;
    count_t     off_right_count;
  } state_t;

  localparam state_t STATE_RESET = '{
    mode:                 MODE_NORMAL,
    saved_side:           SIDE_NONE,
    lamp_bits:            LAMP_NONE,
    normal_hazard_count:  '0,
    normal_phase_count:   '0,
    normal_release_count: '0,
    lane_hazard_count:    '0,
    lane_left_count:      '0,
    lane_right_count:     '0,
    lane_flashes_done:    '0,
    lane_phase_count:     '0,
    hazard_exit_count:    '0,
    hazard_phase_count:   '0,
    off_hazard_count:     '0,
    off_left_count:       '0,
    off_right_count:      '0
  };

  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : v + count_t'(1);
  endfunction

  function automatic logic hold_fire(input count_t cnt, input logic hz, input count_t hold);
    return !hz && (cnt >= hold);
  endfunction

  function automatic count_t hold_count(input count_t cnt, input logic hz);
    return hz ? sat_inc(cnt) : '0;
  endfunction

endpackage

`default_nettype wire

/* hdl/turn_indicator_controller_top.sv */
// Top level of the turn indicator controller: beat registers, state and configuration.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_ready  left_pressed, right_pressed, hazard_pressed
//   out      from block out_valid / out_ready lamp_low, lamp_high, mode_now
//   cfg      to block   cfg_write            cfg_index, cfg_data
//
// One tick beat a cycle while the result is not stalled. An accepted beat is held in
// the input register, which feeds the tick logic; the tick logic updates the state as the
// result register loads. Reset restores the default configuration and the
// normal mode. A stalled result holds; the input register takes one more beat.
`default_nettype none

module turn_indicator_controller_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               left_pressed,
  input  logic                               right_pressed,
  input  logic                               hazard_pressed,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               lamp_low,
  output logic                               lamp_high,
  output logic [1:0]                         mode_now,
  input  logic                               cfg_write,
  input  logic [tic_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [tic_pkg::CfgDataWidth-1:0]   cfg_data
);
  import tic_pkg::*;

  cfg_t       cfg;
  state_t     state;
  state_t     state_next;
  logic [1:0] mode_code;

  logic in_full;
  logic left_q;
  logic right_q;
  logic hazard_q;
  logic advance;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_HAZARD_HOLD:  cfg.hazard_hold_ticks  <= cfg_data;
        CFG_TURN_HOLD:    cfg.turn_hold_ticks    <= cfg_data;
        CFG_RELEASE:      cfg.release_ticks      <= cfg_data;
        CFG_TURN_ON:      cfg.turn_on_ticks      <= cfg_data;
        CFG_FLASH_PERIOD: cfg.flash_period_ticks <= cfg_data;
        CFG_HAZARD_ON:    cfg.hazard_on_ticks    <= cfg_data;
        CFG_LANE_FLASHES: cfg.lane_flash_count   <= cfg_data[FlashWidth-1:0];
        default:          cfg                    <= cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      left_q   <= left_pressed;
      right_q  <= right_pressed;
      hazard_q <= hazard_pressed;
    end
  end

  tic_step u_step (
    .state_cur      (state),
    .cfg            (cfg),
    .left_pressed   (left_q),
    .right_pressed  (right_q),
    .hazard_pressed (hazard_q),
    .state_next     (state_next),
    .mode_code      (mode_code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lamp_low  <= state_next.lamp_bits[0];
      lamp_high <= state_next.lamp_bits[1];
      mode_now  <= mode_code;
    end
  end

endmodule

`default_nettype wire

/* hdl/tic_step.sv */
// Next-state logic for one tick of the turn indicator controller.
`default_nettype none

module tic_step (
  input  tic_pkg::state_t state_cur,
  input  tic_pkg::cfg_t   cfg,
  input  logic            left_pressed,
  input  logic            right_pressed,
  input  logic            hazard_pressed,
  output tic_pkg::state_t state_next,
  output logic [1:0]      mode_code
);
  import tic_pkg::*;

  state_t s;
  logic   fire;
  logic   l;
  logic   r;
  logic   hz;

  assign l  = left_pressed;
  assign r  = right_pressed;
  assign hz = hazard_pressed;

  always_comb begin
    s    = state_cur;
    fire = 1'b0;
    case (state_cur.mode)
      MODE_NORMAL: begin
        fire = hold_fire(s.normal_hazard_count, hz, cfg.hazard_hold_ticks);
        s.normal_hazard_count = hold_count(s.normal_hazard_count, hz);
        if (fire) begin
          s.normal_phase_count   = '0;
          s.normal_release_count = '0;
          s.mode                 = MODE_HAZARD;
        end
        if (!l && !r) begin
          s.normal_release_count = sat_inc(s.normal_release_count);
          if (s.normal_release_count >= cfg.release_ticks) begin
            s.normal_release_count = '0;
            s.normal_phase_count   = '0;
            s.mode                 = MODE_OFF;
          end
        end else begin
          s.normal_phase_count = sat_inc(s.normal_phase_count);
          if (s.normal_phase_count < cfg.turn_on_ticks) begin
            s.lamp_bits = (s.saved_side == SIDE_LEFT) ? LAMP_HIGH : LAMP_LOW;
          end else if (s.normal_phase_count < cfg.flash_period_ticks) begin
            s.lamp_bits = LAMP_NONE;
          end else begin
            s.normal_phase_count = '0;
          end
        end
      end
      MODE_LANE: begin
        fire = hold_fire(s.lane_hazard_count, hz, cfg.hazard_hold_ticks);
        s.lane_hazard_count = hold_count(s.lane_hazard_count, hz);
        if (fire) begin
          s.lane_left_count   = '0;
          s.lane_right_count  = '0;
          s.lane_flashes_done = '0;
          s.lane_phase_count  = '0;
          s.mode              = MODE_HAZARD;
        end
        if (l != r) begin
          s.lane_hazard_count = '0;
          if (l) begin
            s.lane_left_count = sat_inc(s.lane_left_count);
          end else begin
            s.lane_right_count = sat_inc(s.lane_right_count);
          end
          if (s.lane_left_count == cfg.turn_hold_ticks ||
              s.lane_right_count == cfg.turn_hold_ticks) begin
            s.saved_side = (s.lane_right_count < s.lane_left_count) ? SIDE_LEFT : SIDE_RIGHT;
            s.lane_left_count  = '0;
            s.lane_right_count = '0;
            s.mode             = MODE_NORMAL;
          end
        end else if (!l && !r) begin
          s.lane_left_count  = '0;
          s.lane_right_count = '0;
        end
        if (s.lane_flashes_done < cfg.lane_flash_count) begin
          s.lane_phase_count = sat_inc(s.lane_phase_count);
          if (s.lane_phase_count < cfg.turn_on_ticks) begin
            s.lamp_bits = (s.saved_side == SIDE_LEFT) ? LAMP_LOW : LAMP_HIGH;
          end else if (s.lane_phase_count < cfg.flash_period_ticks) begin
            s.lamp_bits = LAMP_NONE;
          end else begin
            s.lane_phase_count  = '0;
            s.lane_flashes_done = s.lane_flashes_done + flash_t'(1);
          end
        end else begin
          s.lane_flashes_done = '0;
          s.lane_phase_count  = '0;
          s.mode              = MODE_OFF;
        end
      end
      MODE_HAZARD: begin
        fire = hold_fire(s.hazard_exit_count, hz, cfg.hazard_hold_ticks);
        s.hazard_exit_count = hold_count(s.hazard_exit_count, hz);
        if (fire) begin
          s.mode = MODE_OFF;
        end
        s.hazard_phase_count = sat_inc(s.hazard_phase_count);
        if (s.hazard_phase_count < cfg.hazard_on_ticks) begin
          s.lamp_bits = LAMP_BOTH;
        end else if (s.hazard_phase_count < cfg.flash_period_ticks) begin
          s.lamp_bits = LAMP_NONE;
        end else begin
          s.hazard_phase_count = '0;
        end
      end
      default: begin
        s.lamp_bits = LAMP_NONE;
        fire = hold_fire(s.off_hazard_count, hz, cfg.hazard_hold_ticks);
        s.off_hazard_count = hold_count(s.off_hazard_count, hz);
        if (fire) begin
          s.mode = MODE_HAZARD;
        end
        if (l != r) begin
          if (l) begin
            s.off_left_count = sat_inc(s.off_left_count);
          end else begin
            s.off_right_count = sat_inc(s.off_right_count);
          end
          if (s.off_left_count == cfg.turn_hold_ticks ||
              s.off_right_count == cfg.turn_hold_ticks) begin
            s.saved_side = (s.off_right_count < s.off_left_count) ? SIDE_LEFT : SIDE_RIGHT;
            s.off_left_count  = '0;
            s.off_right_count = '0;
            s.mode            = MODE_NORMAL;
          end
        end else if (!l && !r) begin
          if ((s.off_left_count != '0 && s.off_left_count < cfg.turn_hold_ticks) ||
              (s.off_right_count != '0 && s.off_right_count < cfg.turn_hold_ticks)) begin
            s.saved_side = (s.off_right_count < s.off_left_count) ? SIDE_LEFT : SIDE_RIGHT;
            s.mode       = MODE_LANE;
          end
          s.off_left_count  = '0;
          s.off_right_count = '0;
        end
      end
    endcase
    state_next = s;
  end

  always_comb begin
    case (s.mode)
      MODE_LANE:   mode_code = MODE_CODE_LANE;
      MODE_NORMAL: mode_code = MODE_CODE_NORMAL;
      MODE_HAZARD: mode_code = MODE_CODE_HAZARD;
      default:     mode_code = MODE_CODE_OFF;
    endcase
  end

endmodule

`default_nettype wire
